// ===== hw/rtl/rti_pkg.sv =====
package rti_pkg;

    // coordinate and derived widths
    localparam int CW    = 16;
    localparam int EW    = CW + 1;
    localparam int NW    = 2 * EW + 1;
    localparam int HW    = CW + EW + 1;
    localparam int QW    = 2 * EW + 1;
    localparam int PHW   = CW + EW;
    localparam int PQW   = 2 * EW;
    localparam int PDW   = NW + CW;
    localparam int PNW   = NW + EW;
    localparam int PUW   = EW + HW;
    localparam int PVW   = CW + QW;
    localparam int DW    = PDW + 2;
    localparam int NUMW  = PNW + 2;
    localparam int UVSW  = DW + 1;

    // distance and division
    localparam int FRAC  = 16;
    localparam int TQW   = 32;
    localparam int RW    = DW + 1;
    localparam int SATW  = DW + FRAC + 1;

    // hit point
    localparam int PRW   = TQW + 1 + CW;
    localparam int RNDW  = PRW + 1;
    localparam int SUMW  = RNDW - FRAC + 1;
    localparam int PW    = 24;
    localparam int PT_MAX     = 2 ** (PW - 1) - 1;
    localparam int PT_MIN     = -(2 ** (PW - 1));
    localparam int ROUND_HALF = 2 ** (FRAC - 1);

    // configuration port
    localparam int CFG_W      = 3 * CW;
    localparam int CFG_IW     = 2;
    localparam int CFG_SETTLE = 3;
    localparam int SETTLE_W   = $clog2(CFG_SETTLE + 1);

    localparam logic [CFG_IW-1:0] REG_VERTEX_A = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_VERTEX_B = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_VERTEX_C = CFG_IW'(2);

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [EW-1:0]   edge_t;
    typedef logic signed [NW-1:0]   nrm_t;
    typedef logic signed [DW-1:0]   dot_t;
    typedef logic signed [NUMW-1:0] num_t;

    typedef struct packed {
        coord_t [2:0] o;
        coord_t [2:0] r;
    } ray_t;

    typedef struct packed {
        coord_t [2:0] a;
        edge_t  [2:0] e1;
        edge_t  [2:0] e2;
        nrm_t   [2:0] n;
        logic         nz;
    } tri_t;

    typedef struct packed {
        logic            hit;
        logic            sat;
        logic [RW-1:0]   rem;
        logic [DW-1:0]   dp;
        logic [FRAC-1:0] nlo;
        logic [TQW-1:0]  quo;
        ray_t            ray;
    } div_t;

    typedef struct packed {
        logic           hit;
        logic [TQW-1:0] tq;
        ray_t           ray;
    } res_t;

endpackage

// ===== hw/rtl/rti_cfg.sv =====
module rti_cfg import rti_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output tri_t              tri_info,
    output logic              busy
);

    logic [CFG_W-1:0]    va_reg;
    logic [CFG_W-1:0]    vb_reg;
    logic [CFG_W-1:0]    vc_reg;
    logic [SETTLE_W-1:0] settle_reg;

    coord_t a [3];
    coord_t b [3];
    coord_t c [3];

    edge_t                 e1_reg [3];
    edge_t                 e2_reg [3];
    logic signed [PQW-1:0] cp_reg [6];
    nrm_t                  n_next [3];
    nrm_t                  n_reg  [3];
    logic                  nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg     <= '0;
            vb_reg     <= '0;
            vc_reg     <= '0;
            settle_reg <= SETTLE_W'(CFG_SETTLE);
        end
        else
        begin
            if (cfg_we)
            begin
                settle_reg <= SETTLE_W'(CFG_SETTLE);
                case (cfg_index)
                    REG_VERTEX_A: va_reg <= cfg_data;
                    REG_VERTEX_B: vb_reg <= cfg_data;
                    REG_VERTEX_C: vc_reg <= cfg_data;
                    default: ;
                endcase
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - SETTLE_W'(1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a[i] = va_reg[i*CW +: CW];
            b[i] = vb_reg[i*CW +: CW];
            c[i] = vc_reg[i*CW +: CW];
        end
    end

    // edges, cross terms, normal
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_reg[i] <= EW'(b[i]) - EW'(a[i]);
            e2_reg[i] <= EW'(c[i]) - EW'(a[i]);
        end
        cp_reg[0] <= e1_reg[1] * e2_reg[2];
        cp_reg[1] <= e1_reg[2] * e2_reg[1];
        cp_reg[2] <= e1_reg[2] * e2_reg[0];
        cp_reg[3] <= e1_reg[0] * e2_reg[2];
        cp_reg[4] <= e1_reg[0] * e2_reg[1];
        cp_reg[5] <= e1_reg[1] * e2_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            n_reg[i] <= n_next[i];
        end
        nz_reg <= (n_next[0] != '0) || (n_next[1] != '0) || (n_next[2] != '0);
    end

    always_comb
    begin
        n_next[0] = NW'(cp_reg[0]) - NW'(cp_reg[1]);
        n_next[1] = NW'(cp_reg[2]) - NW'(cp_reg[3]);
        n_next[2] = NW'(cp_reg[4]) - NW'(cp_reg[5]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tri_info.a[i]  = a[i];
            tri_info.e1[i] = e1_reg[i];
            tri_info.e2[i] = e2_reg[i];
            tri_info.n[i]  = n_reg[i];
        end
        tri_info.nz = nz_reg;
    end

    assign busy = (settle_reg != '0);

endmodule

// ===== hw/rtl/rti_geom.sv =====
module rti_geom import rti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_transfer,
    input  ray_t in_ray,
    input  tri_t tri_info,
    output logic s1_valid,
    output logic out_valid,
    output div_t out_data
);

    coord_t o_in [3];
    coord_t a    [3];
    edge_t  e1   [3];
    edge_t  e2   [3];
    nrm_t   n    [3];

    // stage 1: origin relative to vertex a
    logic   v1_reg;
    edge_t  t1_reg [3];
    ray_t   ray1_reg;
    coord_t r1 [3];

    // stage 2: products
    logic                  v2_reg;
    logic signed [PHW-1:0] ph_reg [6];
    logic signed [PQW-1:0] pq_reg [6];
    logic signed [PDW-1:0] pd_reg [3];
    logic signed [PNW-1:0] pn_reg [3];
    edge_t                 t2_reg [3];
    ray_t                  ray2_reg;

    // stage 3: h = r x e2, q = t x e1, determinant, numerator
    logic                 v3_reg;
    logic signed [HW-1:0] h3_reg [3];
    logic signed [QW-1:0] q3_reg [3];
    dot_t                 d3_reg;
    num_t                 num3_reg;
    edge_t                t3_reg [3];
    ray_t                 ray3_reg;
    coord_t               r3 [3];

    // stage 4: barycentric products
    logic                  v4_reg;
    logic signed [PUW-1:0] pu4_reg [3];
    logic signed [PVW-1:0] pv4_reg [3];
    dot_t                  d4_reg;
    num_t                  num4_reg;
    ray_t                  ray4_reg;

    // stage 5: barycentric sums
    logic v5_reg;
    dot_t u5_reg;
    dot_t v5s_reg;
    dot_t d5_reg;
    num_t num5_reg;
    ray_t ray5_reg;

    // stage 6: sign normalization
    logic v6_reg;
    dot_t dp6_reg;
    num_t np6_reg;
    dot_t up6_reg;
    dot_t vp6_reg;
    ray_t ray6_reg;
    logic neg5;

    // stage 7: decision
    logic out_valid_reg;
    div_t out_reg;
    div_t out_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_in[i] = in_ray.o[i];
            a[i]    = tri_info.a[i];
            e1[i]   = tri_info.e1[i];
            e2[i]   = tri_info.e2[i];
            n[i]    = tri_info.n[i];
            r1[i]   = ray1_reg.r[i];
            r3[i]   = ray3_reg.r[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en || !v1_reg)
            begin
                v1_reg <= in_transfer;
            end
            if (en)
            begin
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= v4_reg;
                v6_reg        <= v5_reg;
                out_valid_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t1_reg[i] <= EW'(o_in[i]) - EW'(a[i]);
            end
            ray1_reg <= in_ray;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg[0] <= r1[1] * e2[2];
            ph_reg[1] <= r1[2] * e2[1];
            ph_reg[2] <= r1[2] * e2[0];
            ph_reg[3] <= r1[0] * e2[2];
            ph_reg[4] <= r1[0] * e2[1];
            ph_reg[5] <= r1[1] * e2[0];
            pq_reg[0] <= t1_reg[1] * e1[2];
            pq_reg[1] <= t1_reg[2] * e1[1];
            pq_reg[2] <= t1_reg[2] * e1[0];
            pq_reg[3] <= t1_reg[0] * e1[2];
            pq_reg[4] <= t1_reg[0] * e1[1];
            pq_reg[5] <= t1_reg[1] * e1[0];
            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= n[i] * r1[i];
                pn_reg[i] <= n[i] * t1_reg[i];
                t2_reg[i] <= t1_reg[i];
            end
            ray2_reg <= ray1_reg;

            h3_reg[0] <= HW'(ph_reg[0]) - HW'(ph_reg[1]);
            h3_reg[1] <= HW'(ph_reg[2]) - HW'(ph_reg[3]);
            h3_reg[2] <= HW'(ph_reg[4]) - HW'(ph_reg[5]);
            q3_reg[0] <= QW'(pq_reg[0]) - QW'(pq_reg[1]);
            q3_reg[1] <= QW'(pq_reg[2]) - QW'(pq_reg[3]);
            q3_reg[2] <= QW'(pq_reg[4]) - QW'(pq_reg[5]);
            d3_reg    <= DW'(pd_reg[0]) + DW'(pd_reg[1]) + DW'(pd_reg[2]);
            num3_reg  <= -(NUMW'(pn_reg[0]) + NUMW'(pn_reg[1]) + NUMW'(pn_reg[2]));
            for (int i = 0; i < 3; i++)
            begin
                t3_reg[i] <= t2_reg[i];
            end
            ray3_reg <= ray2_reg;

            for (int i = 0; i < 3; i++)
            begin
                pu4_reg[i] <= t3_reg[i] * h3_reg[i];
                pv4_reg[i] <= r3[i] * q3_reg[i];
            end
            d4_reg   <= d3_reg;
            num4_reg <= num3_reg;
            ray4_reg <= ray3_reg;

            u5_reg   <= DW'(pu4_reg[0]) + DW'(pu4_reg[1]) + DW'(pu4_reg[2]);
            v5s_reg  <= DW'(pv4_reg[0]) + DW'(pv4_reg[1]) + DW'(pv4_reg[2]);
            d5_reg   <= d4_reg;
            num5_reg <= num4_reg;
            ray5_reg <= ray4_reg;

            dp6_reg  <= neg5 ? -d5_reg : d5_reg;
            np6_reg  <= neg5 ? -num5_reg : num5_reg;
            up6_reg  <= neg5 ? u5_reg : -u5_reg;
            vp6_reg  <= neg5 ? v5s_reg : -v5s_reg;
            ray6_reg <= ray5_reg;

            out_reg <= out_next;
        end
    end

    assign neg5 = d5_reg[DW-1];

    always_comb
    begin
        out_next.hit = tri_info.nz && (dp6_reg != '0) && !np6_reg[NUMW-1]
                     && !up6_reg[DW-1] && !vp6_reg[DW-1]
                     && ((UVSW'(up6_reg) + UVSW'(vp6_reg)) <= UVSW'(dp6_reg));
        out_next.sat = SATW'(np6_reg) >= (SATW'(dp6_reg) <<< FRAC);
        out_next.rem = RW'(np6_reg >>> FRAC);
        out_next.dp  = dp6_reg;
        out_next.nlo = np6_reg[FRAC-1:0];
        out_next.quo = '0;
        out_next.ray = ray6_reg;
    end

    assign s1_valid  = v1_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/rti_div.sv =====
module rti_div import rti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output res_t out_data
);

    logic v_reg  [TQW];
    div_t st_reg [TQW];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < TQW; k++)
    begin : g_step
        localparam int B = TQW - 1 - k;
        div_t          prev;
        logic          prev_v;
        logic          sh_bit;
        logic [RW-1:0] rem2;
        logic          ge;
        div_t          st_next;

        if (k == 0)
        begin : g_first
            assign prev   = in_data;
            assign prev_v = in_valid;
        end
        else
        begin : g_chain
            assign prev   = st_reg[k-1];
            assign prev_v = v_reg[k-1];
        end

        if (B >= FRAC)
        begin : g_num_bit
            assign sh_bit = prev.nlo[B-FRAC];
        end
        else
        begin : g_zero_bit
            assign sh_bit = 1'b0;
        end

        assign rem2 = {prev.rem[RW-2:0], sh_bit};
        assign ge   = rem2 >= {1'b0, prev.dp};

        always_comb
        begin
            st_next        = prev;
            st_next.rem    = ge ? (rem2 - {1'b0, prev.dp}) : rem2;
            st_next.quo[B] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= prev_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= st_next;
            end
        end
    end

    assign out_valid    = v_reg[TQW-1];
    assign out_data.hit = st_reg[TQW-1].hit;
    assign out_data.tq  = st_reg[TQW-1].sat ? '1 : st_reg[TQW-1].quo;
    assign out_data.ray = st_reg[TQW-1].ray;

endmodule

// ===== hw/rtl/rti_point.sv =====
module rti_point import rti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  res_t                 in_data,
    output logic                 out_valid,
    output logic                 hit,
    output logic [TQW-1:0]       distance,
    output logic signed [PW-1:0] point_x,
    output logic signed [PW-1:0] point_y,
    output logic signed [PW-1:0] point_z
);

    coord_t r_in [3];

    logic                  v1_reg;
    logic                  hit1_reg;
    logic [TQW-1:0]        tq1_reg;
    coord_t                o1_reg   [3];
    logic signed [PRW-1:0] prod_reg [3];

    logic signed [RNDW-1:0] rnd  [3];
    logic signed [SUMW-1:0] psum [3];
    logic signed [PW-1:0]   pt_next [3];

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [TQW-1:0]       distance_reg;
    logic signed [PW-1:0] pt_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_in[i] = in_data.ray.r[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            out_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit1_reg <= in_data.hit;
            tq1_reg  <= in_data.tq;
            for (int i = 0; i < 3; i++)
            begin
                o1_reg[i]   <= in_data.ray.o[i];
                prod_reg[i] <= $signed({1'b0, in_data.tq}) * r_in[i];
            end
        end
    end

    // round half up, add origin, clamp
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i]  = RNDW'(prod_reg[i]) + RNDW'(ROUND_HALF);
            psum[i] = SUMW'(o1_reg[i]) + SUMW'(rnd[i] >>> FRAC);
            if (psum[i] > PT_MAX)
            begin
                pt_next[i] = PW'(PT_MAX);
            end
            else if (psum[i] < PT_MIN)
            begin
                pt_next[i] = PW'(PT_MIN);
            end
            else
            begin
                pt_next[i] = PW'(psum[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg      <= hit1_reg;
            distance_reg <= hit1_reg ? tq1_reg : '0;
            for (int i = 0; i < 3; i++)
            begin
                pt_reg[i] <= hit1_reg ? pt_next[i] : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign distance  = distance_reg;
    assign point_x   = pt_reg[0];
    assign point_y   = pt_reg[1];
    assign point_z   = pt_reg[2];

endmodule

// ===== hw/rtl/ray_triangle_intersect_core.sv =====
// path: a ray runs through the geometry, divider and hit point stages to the output
// throughput: one ray per cycle when not stalled or busy; divider: 32 stages, one bit each
// stall: a blocked output freezes the pipeline; an empty first stage still takes a ray
// reset: valid bits cleared, vertices cleared to zero
// input is held off after reset and after every register write until the settle count runs out
module ray_triangle_intersect_core import rti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] origin_x,
    input  logic signed [CW-1:0] origin_y,
    input  logic signed [CW-1:0] origin_z,
    input  logic signed [CW-1:0] dir_x,
    input  logic signed [CW-1:0] dir_y,
    input  logic signed [CW-1:0] dir_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [TQW-1:0]       distance,
    output logic signed [PW-1:0] point_x,
    output logic signed [PW-1:0] point_y,
    output logic signed [PW-1:0] point_z
);

    tri_t tri_info;
    logic busy;
    logic en;
    logic s1_valid;
    logic in_transfer;
    ray_t in_ray;
    logic geom_valid;
    div_t geom_data;
    logic div_valid;
    res_t div_data;

    assign en          = !out_valid || out_ready;
    assign in_ready    = (en || !s1_valid) && !busy;
    assign in_transfer = in_valid && in_ready;

    assign in_ray.o[0] = origin_x;
    assign in_ray.o[1] = origin_y;
    assign in_ray.o[2] = origin_z;
    assign in_ray.r[0] = dir_x;
    assign in_ray.r[1] = dir_y;
    assign in_ray.r[2] = dir_z;

    rti_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tri_info  (tri_info),
        .busy      (busy)
    );

    rti_geom u_geom
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_transfer (in_transfer),
        .in_ray      (in_ray),
        .tri_info    (tri_info),
        .s1_valid    (s1_valid),
        .out_valid   (geom_valid),
        .out_data    (geom_data)
    );

    rti_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (geom_valid),
        .in_data   (geom_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    rti_point u_point
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (out_valid),
        .hit       (hit),
        .distance  (distance),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z)
    );

    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("transfer accepted right after a register write");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (distance == '0) && (point_x == '0)
                              && (point_y == '0) && (point_z == '0))
        else $error("miss with nonzero result fields");

    a_hit_needs_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> tri_info.nz)
        else $error("hit reported on a degenerate triangle");

endmodule
